/* rtl/core/ltc_pkg.sv */
package ltc_pkg;

    localparam int FUNC_W        = 2;
    localparam int NODE_FIELD_W  = 6;
    localparam int LABEL_FIELD_W = 26;
    localparam int MASK_OUT_W    = 26;
    localparam int CFG_W         = 7;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_CLOSE = 2'd2,
        FUNC_QUERY = 2'd3
    } ltc_func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_WR,
        ST_K_READ,
        ST_I_LOOP,
        ST_I_LAST,
        ST_FINISH
    } ltc_state_t;

    typedef struct packed {
        logic load_item;
        logic clear;
        logic rd_en;
        logic rd_src;
        logic wr_add;
        logic wr_close;
        logic load_rowk;
        logic out_load;
    } ltc_cmd_t;

    typedef struct packed {
        ltc_func_t func;
        logic      in_range;
    } ltc_status_t;

endpackage

/* rtl/core/ltc_req_if.sv */
interface ltc_req_if;
    logic                             valid;
    logic                             ready;
    logic [ltc_pkg::FUNC_W-1:0]       func;
    logic [ltc_pkg::NODE_FIELD_W-1:0] src_node;
    logic [ltc_pkg::NODE_FIELD_W-1:0] dst_node;
    logic [ltc_pkg::LABEL_FIELD_W-1:0] label_mask;

    modport source (output valid, func, src_node, dst_node, label_mask, input ready);
    modport sink (input valid, func, src_node, dst_node, label_mask, output ready);
endinterface

/* rtl/core/ltc_rsp_if.sv */
interface ltc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ltc_pkg::MASK_OUT_W-1:0] reach_mask;
    logic [ltc_pkg::FUNC_W-1:0]     op_done;

    modport source (output valid, reach_mask, op_done, input ready);
    modport sink (input valid, reach_mask, op_done, output ready);
endinterface

/* rtl/core/ltc_cfg_if.sv */
interface ltc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ltc_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/core/ltc_ctrl.sv */
module ltc_ctrl #(
    parameter int MAX_NODES = 64,
    parameter int NODE_W    = 6,
    parameter int CNT_W     = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ltc_pkg::CFG_W-1:0] cfg_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  ltc_pkg::ltc_status_t     status,
    output ltc_pkg::ltc_cmd_t        cmd,
    output logic [NODE_W-1:0]        row_idx,
    output logic [NODE_W-1:0]        k_idx,
    output logic [CNT_W-1:0]         n_lim
);
    import ltc_pkg::*;

    localparam int NC_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    ltc_state_t       state_reg, state_next;
    logic [NODE_W-1:0] k_reg, k_next;
    logic [NODE_W-1:0] i_reg, i_next;
    logic             out_valid_reg, out_valid_next;
    logic [CFG_W-1:0] nc_reg;
    logic [NC_W-1:0]  nc_ext;
    logic [CNT_W-1:0] n_m1;
    logic             slot_free;

    // The closure never walks beyond the table, whatever the register holds.
    assign nc_ext = NC_W'(nc_reg);
    assign n_lim  = (nc_ext > NC_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : nc_ext[CNT_W-1:0];
    assign n_m1   = n_lim - 1'b1;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign k_idx     = k_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
            nc_reg        <= NODE_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                nc_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        cmd        = '0;
        row_idx    = i_reg;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.func)
                    FUNC_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    FUNC_ADD:
                    begin
                        cmd.rd_en  = status.in_range;
                        cmd.rd_src = 1'b1;
                        state_next = status.in_range ? ST_ADD_WR : ST_FINISH;
                    end
                    FUNC_CLOSE:
                    begin
                        k_next     = '0;
                        state_next = (n_lim == '0) ? ST_FINISH : ST_K_READ;
                    end
                    FUNC_QUERY:
                    begin
                        cmd.rd_en  = status.in_range;
                        cmd.rd_src = 1'b1;
                        state_next = ST_FINISH;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_ADD_WR:
            begin
                cmd.wr_add = 1'b1;
                state_next = ST_FINISH;
            end
            ST_K_READ:
            begin
                cmd.rd_en  = 1'b1;
                row_idx    = k_reg;
                i_next     = '0;
                state_next = ST_I_LOOP;
            end
            ST_I_LOOP:
            begin
                // Row i is read while row i-1, read in the cycle before, is written back.
                cmd.rd_en     = 1'b1;
                cmd.load_rowk = (i_reg == '0);
                cmd.wr_close  = (i_reg != '0);
                if (CNT_W'(i_reg) == n_m1)
                begin
                    state_next = ST_I_LAST;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_I_LAST:
            begin
                cmd.wr_close = 1'b1;
                if (CNT_W'(k_reg) == n_m1)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_K_READ;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

/* rtl/core/ltc_datapath.sv */
module ltc_datapath #(
    parameter int MAX_NODES  = 64,
    parameter int NUM_LABELS = 26,
    parameter int NODE_W     = 6,
    parameter int CNT_W      = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ltc_pkg::FUNC_W-1:0]        func,
    input  logic [ltc_pkg::NODE_FIELD_W-1:0]  src_node,
    input  logic [ltc_pkg::NODE_FIELD_W-1:0]  dst_node,
    input  logic [ltc_pkg::LABEL_FIELD_W-1:0] label_mask,
    input  ltc_pkg::ltc_cmd_t                cmd,
    input  logic [NODE_W-1:0]                row_idx,
    input  logic [NODE_W-1:0]                k_idx,
    input  logic [CNT_W-1:0]                 n_lim,
    output ltc_pkg::ltc_status_t             status,
    output logic [ltc_pkg::MASK_OUT_W-1:0]    reach_mask,
    output logic [ltc_pkg::FUNC_W-1:0]        op_done
);
    import ltc_pkg::*;

    localparam int CMP_W = (NODE_FIELD_W > CNT_W) ? NODE_FIELD_W : CNT_W;
    localparam int LAB_W = (NUM_LABELS > LABEL_FIELD_W) ? NUM_LABELS : LABEL_FIELD_W;

    typedef logic [MAX_NODES-1:0][NUM_LABELS-1:0] row_t;

    row_t row_mem [MAX_NODES];

    logic [FUNC_W-1:0]        func_reg;
    logic [NODE_FIELD_W-1:0]  src_reg;
    logic [NODE_FIELD_W-1:0]  dst_reg;
    logic [LABEL_FIELD_W-1:0] label_reg;
    row_t                     mem_q_reg;
    row_t                     rowk_reg;
    logic                     rd_valid_reg;
    logic [NODE_W-1:0]        rd_addr_reg;
    logic [MAX_NODES-1:0]     valid_reg;
    logic [MASK_OUT_W-1:0]    reach_reg;
    logic [FUNC_W-1:0]        op_done_reg;

    logic [CMP_W-1:0]      src_c;
    logic [CMP_W-1:0]      dst_c;
    logic [NODE_W-1:0]     src_idx;
    logic [NODE_W-1:0]     dst_idx;
    logic                  in_range;
    logic [LAB_W-1:0]      lab_wide;
    logic [NUM_LABELS-1:0] lab;
    logic [NODE_W-1:0]     rd_addr;
    logic                  wr_en;
    row_t                  diag_row;
    row_t                  rd_row;
    row_t                  add_row;
    row_t                  close_row;
    row_t                  wr_row;
    logic [NUM_LABELS-1:0] via;
    logic [LAB_W-1:0]      entry_wide;

    assign src_c    = CMP_W'(src_reg);
    assign dst_c    = CMP_W'(dst_reg);
    assign src_idx  = src_c[NODE_W-1:0];
    assign dst_idx  = dst_c[NODE_W-1:0];
    assign in_range = (src_c < CMP_W'(MAX_NODES)) && (dst_c < CMP_W'(MAX_NODES));
    assign lab_wide = LAB_W'(label_reg);
    assign lab      = lab_wide[NUM_LABELS-1:0];

    assign status.func     = ltc_func_t'(func_reg);
    assign status.in_range = in_range;

    assign rd_addr = cmd.rd_src ? src_idx : row_idx;
    assign wr_en   = cmd.wr_add || cmd.wr_close;

    // A row that has not been written since the last clear reads as the cleared row.
    always_comb
    begin
        for (int c = 0; c < MAX_NODES; c++)
        begin
            diag_row[c] = (NODE_W'(c) == rd_addr_reg) ? {NUM_LABELS{1'b1}} : '0;
        end
        rd_row = rd_valid_reg ? mem_q_reg : diag_row;
        via    = rd_row[k_idx];
        for (int c = 0; c < MAX_NODES; c++)
        begin
            add_row[c] = rd_row[c] | ((NODE_W'(c) == dst_idx) ? lab : '0);
            if (CNT_W'(c) < n_lim)
            begin
                close_row[c] = rd_row[c] | (via & rowk_reg[c]);
            end
            else
            begin
                close_row[c] = rd_row[c];
            end
        end
        wr_row     = cmd.wr_add ? add_row : close_row;
        entry_wide = LAB_W'(rd_row[dst_idx]);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[rd_addr_reg] <= wr_row;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= row_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg  <= func;
            src_reg   <= src_node;
            dst_reg   <= dst_node;
            label_reg <= label_mask;
        end
        if (cmd.rd_en)
        begin
            rd_addr_reg  <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (cmd.load_rowk)
        begin
            rowk_reg <= rd_row;
        end
        if (cmd.out_load)
        begin
            op_done_reg <= func_reg;
            if ((ltc_func_t'(func_reg) == FUNC_QUERY) && in_range)
            begin
                reach_reg <= entry_wide[MASK_OUT_W-1:0];
            end
            else
            begin
                reach_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[rd_addr_reg] <= 1'b1;
        end
    end

    assign reach_mask = reach_reg;
    assign op_done    = op_done_reg;

endmodule

/* rtl/core/labeled_transitive_closure_top.sv */
// An item is taken in ST_IDLE and decoded in ST_DECODE. Clear and query, and an add-edge
// outside the table, go on to ST_FINISH; an add-edge writes its row in ST_ADD_WR; a
// closure over n nodes walks ST_K_READ, ST_I_LOOP and ST_I_LAST for each k, with one row
// read and one row write-back per cycle on the single table memory. The next item can be
// taken in the cycle after the previous result has been loaded into the output register.
// Reset clears the row valid bits, so the table reads as cleared at once; node_count is 64.
module labeled_transitive_closure_top #(
    parameter int MAX_NODES  = 64,
    parameter int NUM_LABELS = 26
) (
    input logic      clk,
    input logic      rst_n,
    ltc_req_if.sink  req,
    ltc_rsp_if.source rsp,
    ltc_cfg_if.sink  cfg
);
    import ltc_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    ltc_cmd_t          cmd;
    ltc_status_t       status;
    logic [NODE_W-1:0] row_idx;
    logic [NODE_W-1:0] k_idx;
    logic [CNT_W-1:0]  n_lim;

    ltc_ctrl #(
        .MAX_NODES (MAX_NODES),
        .NODE_W    (NODE_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_data  (cfg.data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd),
        .row_idx   (row_idx),
        .k_idx     (k_idx),
        .n_lim     (n_lim)
    );

    ltc_datapath #(
        .MAX_NODES  (MAX_NODES),
        .NUM_LABELS (NUM_LABELS),
        .NODE_W     (NODE_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (req.func),
        .src_node   (req.src_node),
        .dst_node   (req.dst_node),
        .label_mask (req.label_mask),
        .cmd        (cmd),
        .row_idx    (row_idx),
        .k_idx      (k_idx),
        .n_lim      (n_lim),
        .status     (status),
        .reach_mask (rsp.reach_mask),
        .op_done    (rsp.op_done)
    );

endmodule
